@@ hdl/bsq_pkg.sv @@
// ----------------------------------------------------------------------------
// bsq_pkg
// Types and codes shared by the bounded sorted priority queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

	localparam int CNT_W = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [30:0] pid;
		logic [31:0] key;
		logic [31:0] ip_address;
		logic [15:0] port_number;
		logic [7:0]  addr_length;
	} req_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [30:0]      out_pid;
		logic [31:0]      out_key;
		logic [31:0]      out_address;
		logic [15:0]      out_port;
		logic [7:0]       out_length;
		logic [CNT_W-1:0] occupancy;
	} rsp_word_t;

	typedef struct packed {
		logic [30:0] pid;
		logic [31:0] key;
		logic [31:0] addr;
		logic [15:0] port;
		logic [7:0]  len;
	} entry_t;

	// shared per-cycle command to every cell
	typedef struct packed {
		logic        ins;
		logic        rem;
		logic        look;
		entry_t      fresh;
	} cell_ctl_t;

	// per-cell flags
	typedef struct packed {
		logic shift;
		logic hit;
	} cell_sts_t;

endpackage

@@ hdl/bounded_sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue_unit
// Sorted shift-register priority queue: insert, pop front, pid lookup.
// The result word is registered when the request is taken.
// Throughput: one word per cycle while the receiver does not stall; all cells compare and shift in parallel.
// Reset: count cleared, capacity set to 16, slot contents undefined.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [4:0]             cfg_data,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  bsq_pkg::req_word_t     req_word,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output bsq_pkg::rsp_word_t     rsp_word
);
	import bsq_pkg::*;

	localparam int LIM = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_eff;
	logic [CNT_W-1:0] count_next;
	logic             accept;
	logic             full;
	logic             empty;
	logic             ins_ok;
	logic             rem_ok;
	cell_ctl_t        ctl;
	rsp_word_t        rsp_d;

	entry_t    entries [MAX_ENTRIES];
	cell_sts_t sts     [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hits;

	assign cfg_ready = 1'b1;
	assign req_stall = rsp_valid && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign cap_eff = (cap_q > CNT_W'(LIM)) ? CNT_W'(LIM) : cap_q;
	assign full    = count_q >= cap_eff;
	assign empty   = count_q == '0;
	assign ins_ok  = accept && (req_word.cmd == CMD_INSERT) && !full;
	assign rem_ok  = accept && (req_word.cmd == CMD_REMOVE) && !empty;

	assign ctl.ins         = ins_ok;
	assign ctl.rem         = rem_ok;
	assign ctl.look        = req_word.cmd == CMD_LOOKUP;
	assign ctl.fresh.pid   = req_word.pid;
	assign ctl.fresh.key   = req_word.key;
	assign ctl.fresh.addr  = req_word.ip_address;
	assign ctl.fresh.port  = req_word.port_number;
	assign ctl.fresh.len   = req_word.addr_length;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic occ;
		logic shl;
		if (i < 32) begin : g_occ
			assign occ = count_q > CNT_W'(i);
		end else begin : g_none
			assign occ = 1'b0;
		end
		if (i == 0) begin : g_head
			assign shl = 1'b0;
		end else begin : g_body
			assign shl = sts[i-1].shift;
		end
		assign hits[i] = sts[i].hit;

		bsq_cell u_cell (
			.clk          (clk),
			.is_head      (i == 0),
			.occupied     (occ),
			.shift_left_nb(shl),
			.ctl          (ctl),
			.left_entry   (entries[(i == 0) ? 0 : i-1]),
			.right_entry  (entries[(i == MAX_ENTRIES-1) ? i : i+1]),
			.entry        (entries[i]),
			.sts          (sts[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + 1'b1;
		end else if (rem_ok) begin
			count_next = count_q - 1'b1;
		end
	end

	always_comb begin
		rsp_d           = '0;
		rsp_d.occupancy = count_next;
		unique case (req_word.cmd)
			CMD_INSERT: begin
				rsp_d.status = full ? ST_FULL : ST_OK;
			end
			CMD_REMOVE: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.out_pid     = entries[0].pid;
					rsp_d.out_key     = entries[0].key;
					rsp_d.out_address = entries[0].addr;
					rsp_d.out_port    = entries[0].port;
					rsp_d.out_length  = entries[0].len;
				end
			end
			CMD_LOOKUP: begin
				rsp_d.found = |hits;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			count_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			count_q <= count_next;
			if (accept) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_word <= rsp_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.occupancy <= CNT_W'(LIM))
		else $error("occupancy above limit");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == ST_EMPTY |-> rsp_word.occupancy == '0)
		else $error("empty status with entries held");

	a_pop_front: assert property (@(posedge clk) disable iff (!arst_n)
		rem_ok |=> rsp_word.out_key == $past(entries[0].key))
		else $error("pop did not return front key");

endmodule

@@ hdl/bsq_cell.sv @@
// ----------------------------------------------------------------------------
// bsq_cell
// One queue slot: holds an entry, decides whether it yields to a new entry,
// shifts right on insert, left on remove, and matches a lookup pid.
// ----------------------------------------------------------------------------
module bsq_cell (
	input  logic               clk,
	input  logic               is_head,
	input  logic               occupied,
	input  logic               shift_left_nb,
	input  bsq_pkg::cell_ctl_t ctl,
	input  bsq_pkg::entry_t    left_entry,
	input  bsq_pkg::entry_t    right_entry,
	output bsq_pkg::entry_t    entry,
	output bsq_pkg::cell_sts_t sts
);
	import bsq_pkg::*;

	entry_t entry_q;
	logic   new_less;
	logic   own_less;
	logic   yields;

	assign new_less = $signed(ctl.fresh.key) < $signed(entry_q.key);
	assign own_less = $signed(entry_q.key) < $signed(ctl.fresh.key);
	// head yields only to a strictly smaller key, the rest to a key not above
	assign yields = is_head ? new_less : !own_less;

	assign sts.shift = !occupied || yields;
	assign sts.hit   = ctl.look && occupied && (entry_q.pid == ctl.fresh.pid);
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && sts.shift) begin
			entry_q <= shift_left_nb ? left_entry : ctl.fresh;
		end else if (ctl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ bench/tb_bounded_sorted_priority_queue_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_sorted_priority_queue_unit
// Self-checking bench for the sorted priority queue. A scoreboard class keeps
// its own sorted copy of the queue and predicts every reply word: status,
// lookup flag, popped entry and occupancy. A short directed sequence covers
// field extremes, empty remove, unused command and key ties. Random phases
// follow, each at its own capacity. Sender bursts and receiver stall
// patterns vary throughout, and two long receiver holds fill the pipeline.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_priority_queue_unit;

	import bsq_pkg::*;

	localparam int MAX_ENTRIES     = 16;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_CYCLES     = 80;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_PHASES      = 11;
	localparam int TAIL_CYCLES     = 4;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class pq_checker;
		entry_t      slots [MAX_ENTRIES];
		int unsigned held;
		logic [4:0]  capacity;
		rsp_word_t   reply_queue [$];
		int          errors;

		function new();
			held     = 0;
			capacity = CAP_RESET;
			errors   = 0;
		endfunction

		// predict the reply to one accepted request word
		function void take_request(req_word_t rq);
			rsp_word_t   want;
			int unsigned limit;
			int unsigned pos;
			want  = '0;
			limit = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
			case (rq.cmd)
				CMD_INSERT: begin
					if (held < limit) begin
						if (held == 0 || $signed(rq.key) < $signed(slots[0].key)) begin
							pos = 0;
						end else begin
							pos = 1;
							while (pos < held && $signed(slots[pos].key) < $signed(rq.key))
								pos++;
						end
						for (int unsigned i = held; i > pos; i--)
							slots[i] = slots[i-1];
						slots[pos] = '{pid: rq.pid, key: rq.key, addr: rq.ip_address,
							port: rq.port_number, len: rq.addr_length};
						held++;
					end else begin
						want.status = ST_FULL;
					end
				end
				CMD_REMOVE: begin
					if (held == 0) begin
						want.status = ST_EMPTY;
					end else begin
						want.out_pid     = slots[0].pid;
						want.out_key     = slots[0].key;
						want.out_address = slots[0].addr;
						want.out_port    = slots[0].port;
						want.out_length  = slots[0].len;
						for (int unsigned i = 0; i + 1 < held; i++)
							slots[i] = slots[i+1];
						held--;
					end
				end
				CMD_LOOKUP: begin
					for (int unsigned i = 0; i < held; i++)
						if (slots[i].pid == rq.pid)
							want.found = 1'b1;
				end
				default: ;
			endcase
			want.occupancy = held[4:0];
			reply_queue.push_back(want);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
			errors++;
		endtask

		task check_reply(rsp_word_t got);
			rsp_word_t want;
			if (reply_queue.size() == 0) begin
				report("reply word with none pending, status", 32'(got.status), '0);
			end else begin
				want = reply_queue.pop_front();
				if (got.status !== want.status)
					report("status", 32'(got.status), 32'(want.status));
				if (got.found !== want.found)
					report("found", 32'(got.found), 32'(want.found));
				if (got.out_pid !== want.out_pid)
					report("out_pid", 32'(got.out_pid), 32'(want.out_pid));
				if (got.out_key !== want.out_key)
					report("out_key", got.out_key, want.out_key);
				if (got.out_address !== want.out_address)
					report("out_address", got.out_address, want.out_address);
				if (got.out_port !== want.out_port)
					report("out_port", 32'(got.out_port), 32'(want.out_port));
				if (got.out_length !== want.out_length)
					report("out_length", 32'(got.out_length), 32'(want.out_length));
				if (got.occupancy !== want.occupancy)
					report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [4:0] cfg_data;
	logic       req_valid;
	logic       req_stall;
	req_word_t  req_word;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_word_t  rsp_word;

	pq_checker  sb;
	bit         hold_request;
	int         cycle_count;
	logic [4:0] cap_plan [0:NUM_PHASES-1];

	bounded_sorted_priority_queue_unit #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic req_word_t make_word(logic [1:0] cmd, logic [30:0] pid,
		logic [31:0] key, logic [31:0] addr, logic [15:0] port, logic [7:0] len);
		req_word_t w;
		w = '{cmd: cmd, pid: pid, key: key, ip_address: addr,
			port_number: port, addr_length: len};
		return w;
	endfunction

	task automatic send_word(req_word_t w);
		@(negedge clk);
		req_valid <= 1'b1;
		req_word  <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.take_request(w);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	task automatic drain_replies();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.reply_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.capacity = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reply side
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
			sb.check_reply(rsp_word);
	end

	// receiver stall patterns, plus a long hold on request
	initial begin : stall_gen
		int mode;
		int mode_left;
		int hold_left;
		int period;
		int tick;
		rsp_stall = 1'b0;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		period    = 3;
		tick      = 0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_left == 0) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(40, 200);
				period    = $urandom_range(2, 5);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 9) < 3);
					2: rsp_stall <= ($urandom_range(0, 9) < 7);
					default: rsp_stall <= (tick % period == 0);
				endcase
			end
		end
	end

	initial begin : main_seq
		int          n_sent;
		int          burst_left;
		int          r;
		int          ins_pct;
		logic [31:0] rnd;
		req_word_t   w;
		sb           = new();
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		req_valid    = 1'b0;
		req_word     = '0;
		hold_request = 1'b0;
		cap_plan     = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'd17, 5'd2, 5'd16, 5'd8, 5'd3, 5'd30};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_capacity(CAP_RESET);

		// empty queue, unused command, field extremes
		send_word(make_word(CMD_REMOVE, '0, '0, '0, '0, '0));
		send_word(make_word(CMD_LOOKUP, '0, '0, '0, '0, '0));
		send_word(make_word(CMD_UNUSED, '1, '1, '1, '1, '1));
		send_word(make_word(CMD_INSERT, '1, 32'h7FFF_FFFF, '1, '1, '1));
		send_word(make_word(CMD_INSERT, '0, 32'h8000_0000, '0, '0, '0));
		// ties: equal to a later key, then equal to the front key
		send_word(make_word(CMD_INSERT, 31'd1, 32'd0, 32'h0A00_0001, 16'd80, 8'd4));
		send_word(make_word(CMD_INSERT, 31'd2, 32'd0, 32'h0A00_0002, 16'd81, 8'd4));
		send_word(make_word(CMD_INSERT, 31'd3, 32'h8000_0000, 32'h0A00_0003, 16'd82, 8'd16));
		send_word(make_word(CMD_INSERT, 31'd4, 32'hFFFF_FFFF, 32'hC0A8_0001, 16'd443, 8'd4));
		send_word(make_word(CMD_INSERT, 31'd5, 32'd0, 32'h5555_5555, 16'h5555, 8'h55));
		send_word(make_word(CMD_LOOKUP, '1, '0, '0, '0, '0));
		send_word(make_word(CMD_LOOKUP, 31'd9, '0, '0, '0, '0));
		send_word(make_word(CMD_LOOKUP, 31'd2, '1, '1, '1, '1));
		send_word(make_word(CMD_UNUSED, 31'd2, '0, '0, '0, '0));
		repeat (8)
			send_word(make_word(CMD_REMOVE, '1, '1, '1, '1, '1));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_replies();
			write_capacity(ph == 9 ? 5'($urandom_range(0, 31)) : cap_plan[ph]);
			case (ph % 3)
				0: ins_pct = 70;
				1: ins_pct = 45;
				default: ins_pct = 25;
			endcase
			if (ph == 3 || ph == 7)
				hold_request = 1'b1;
			n_sent     = 0;
			burst_left = $urandom_range(1, 24);
			while (n_sent < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < ins_pct)
					w.cmd = CMD_INSERT;
				else if (r < ins_pct + (97 - ins_pct) * 2 / 3)
					w.cmd = CMD_REMOVE;
				else if (r < 97)
					w.cmd = CMD_LOOKUP;
				else
					w.cmd = CMD_UNUSED;
				rnd = $urandom;
				if ($urandom_range(0, 1))
					w.pid = 31'($urandom_range(0, 15));
				else
					w.pid = rnd[30:0];
				r = $urandom_range(0, 9);
				if (r < 4) begin
					w.key = $urandom_range(0, 7) - 32'd4;
				end else if (r < 8) begin
					w.key = $urandom;
				end else begin
					case ($urandom_range(0, 3))
						0: w.key = 32'h8000_0000;
						1: w.key = 32'h7FFF_FFFF;
						2: w.key = '0;
						default: w.key = '1;
					endcase
				end
				w.ip_address  = $urandom;
				rnd           = $urandom;
				w.port_number = rnd[15:0];
				w.addr_length = rnd[23:16];
				send_word(w);
				if (w.cmd != CMD_UNUSED)
					n_sent++;
				burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) != 0)
						idle_cycles($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
			end
		end

		drain_replies();
		if (sb.reply_queue.size() != 0)
			sb.report("reply words left pending", sb.reply_queue.size(), '0);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
